// ----- design/fsa_pkg.sv -----
// Shared types and constants of the fluctuation susceptibility accumulator.
`default_nettype none
package fsa_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int COUNT_BITS   = 24;
  localparam int EL_W         = 6;
  localparam int MEM_DEPTH    = 1 << EL_W;
  localparam int NCOMP        = 4;
  localparam int S1_W         = 40;
  localparam int S2_W         = 56;
  localparam int DIV_W        = 56;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [EL_W-1:0]    element;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic [15:0]        mag_len;
    logic               sample_end;
    logic [23:0]        inv_temperature;
    logic [31:0]        saturation_value;
  } in_item_t;

  typedef struct packed {
    logic [EL_W-1:0]    element_out;
    logic signed [31:0] sus_x;
    logic signed [31:0] sus_y;
    logic signed [31:0] sus_z;
    logic signed [31:0] sus_len;
    logic               no_samples;
  } out_item_t;

endpackage
`default_nettype wire

// ----- design/fsa_divider.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module fsa_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [fsa_pkg::DIV_W-1:0]      dividend,
  input  wire logic [fsa_pkg::COUNT_BITS-1:0] divisor,
  output logic                                done,
  output logic [fsa_pkg::DIV_W-1:0]           quotient
);

  localparam int CW = $clog2(fsa_pkg::DIV_W + 1);
  localparam int CB = fsa_pkg::COUNT_BITS;

  logic [CB-1:0] rem;
  logic [CB-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [CB:0]   trial;
  logic          qbit;

  always_comb begin
    trial = {rem, quotient[fsa_pkg::DIV_W-1]};
    qbit  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CW'(fsa_pkg::DIV_W);
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= qbit ? CB'(trial - {1'b0, dvs}) : trial[CB-1:0];
      quotient <= {quotient[fsa_pkg::DIV_W-2:0], qbit};
      cnt      <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/fluctuation_susceptibility_accumulator.sv -----
// Top level of the fluctuation susceptibility accumulator.
// Per element the block keeps running sums and squared sums of four components in
// row-wide memories with a registered read. An accumulate transfer goes through
// read, square and write back; clear and load complete in the accepting state. A read
// passes the four components one after another through a pair of 56-step
// serial dividers, a squaring step and a four-step 28 x 28 product. A read with a
// zero count or an absent element skips the dividers. The result waits in an
// output register while the next item is taken. No clearing pass is needed after
// reset: a valid bit per element marks rows that hold sums.
`default_nettype none
module fluctuation_susceptibility_accumulator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire fsa_pkg::in_item_t  item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output fsa_pkg::out_item_t      result
);

  localparam int EW  = fsa_pkg::EL_W;
  localparam int NC  = fsa_pkg::NCOMP;
  localparam int W1  = fsa_pkg::S1_W;
  localparam int W2  = fsa_pkg::S2_W;
  localparam int CB  = fsa_pkg::COUNT_BITS;
  localparam int DW  = fsa_pkg::DIV_W;
  localparam int MD  = fsa_pkg::MEM_DEPTH;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC_SQ, ST_ACC_WR, ST_RD_PREF, ST_RD_DIV, ST_RD_WAIT,
    ST_RD_SQ, ST_RD_VAR, ST_RD_MUL, ST_RD_RES, ST_RD_OUT
  } state_t;

  state_t state;

  logic [NC*W1-1:0] s1_mem [MD];
  logic [NC*W2-1:0] s2_mem [MD];
  logic [31:0]      sat_mem [MD];
  logic [MD-1:0]    row_set;

  logic [NC*W1-1:0] s1_row;
  logic [NC*W2-1:0] s2_row;
  logic [31:0]      sat_rd;
  logic             row_ok;

  logic             accept;
  logic             present;
  logic             mem_rd;
  logic [EW-1:0]    el;
  logic [CB-1:0]    count;
  logic [23:0]      itemp;
  logic             zero_res;
  logic             no_samp;

  logic signed [15:0] vv [NC];
  logic signed [15:0] v_next [NC];
  logic [30:0]        sq [NC];
  logic [NC*W1-1:0]   s1_new;
  logic [NC*W2-1:0]   s2_new;

  logic [1:0]         k;
  logic [55:0]        pref;
  logic [DW-1:0]      q1;
  logic [DW-1:0]      q2;
  logic [33:0]        m1sq;
  logic               var_neg;
  logic [55:0]        var_mag;
  logic [111:0]       acc;
  logic [1:0]         mstep;
  logic [31:0]        sus [NC];

  logic               div_start;
  logic               div1_done;
  logic               div2_done;
  logic [W1-1:0]      s1_k;
  logic [W1-1:0]      s1_mag;
  logic [DW-1:0]      dvd1;
  logic [DW-1:0]      dvd2;

  logic [31:0]        m1mag;
  logic [63:0]        m1prod;
  logic [56:0]        diff;
  logic [27:0]        mul_a;
  logic [27:0]        mul_b;
  logic [55:0]        mul_p;
  logic [6:0]         mul_sh;
  logic [31:0]        sus_k;

  assign item_ready = state == ST_IDLE;
  assign accept     = item_valid && item_ready;
  assign present    = 32'(item.element) < fsa_pkg::MAX_ELEMENTS;
  assign mem_rd     = accept && (item.command == fsa_pkg::CMD_ACC ||
                                 item.command == fsa_pkg::CMD_READ);

  // Scaled components of the incoming sample; floor division by 2^16 is a shift.
  always_comb begin
    logic signed [32:0] p [3];
    p[0] = item.mag_x * $signed({1'b0, item.mag_len});
    p[1] = item.mag_y * $signed({1'b0, item.mag_len});
    p[2] = item.mag_z * $signed({1'b0, item.mag_len});
    for (int i = 0; i < 3; i++) begin
      v_next[i] = p[i][31:16];
    end
    v_next[3] = $signed({1'b0, item.mag_len[15:1]});
  end

  // Saturating update of one row; a row never written counts as zero.
  always_comb begin
    logic signed [W1:0] s1s;
    logic [W2:0]        s2s;
    logic [W1-1:0]      s1o;
    logic [W2-1:0]      s2o;
    for (int i = 0; i < NC; i++) begin
      s1o = row_ok ? s1_row[i*W1 +: W1] : '0;
      s2o = row_ok ? s2_row[i*W2 +: W2] : '0;
      s1s = $signed({s1o[W1-1], s1o}) + (W1+1)'(vv[i]);
      s2s = {1'b0, s2o} + (W2+1)'(sq[i]);
      if (s1s[W1] != s1s[W1-1]) begin
        s1_new[i*W1 +: W1] = s1s[W1] ? {1'b1, {(W1-1){1'b0}}} : {1'b0, {(W1-1){1'b1}}};
      end else begin
        s1_new[i*W1 +: W1] = s1s[W1-1:0];
      end
      s2_new[i*W2 +: W2] = s2s[W2] ? {W2{1'b1}} : s2s[W2-1:0];
    end
  end

  // Divider operands for the current component.
  always_comb begin
    s1_k   = row_ok ? s1_row[k*W1 +: W1] : '0;
    s1_mag = s1_k[W1-1] ? W1'(-s1_k) : s1_k;
    dvd1   = {1'b0, s1_mag, 15'b0};
    dvd2   = row_ok ? s2_row[k*W2 +: W2] : '0;
  end

  always_comb begin
    m1mag  = (q1 > DW'(64'h8000_0000)) ? 32'h8000_0000 : q1[31:0];
    m1prod = 64'(m1mag) * 64'(m1mag);
    diff   = {1'b0, q2} - 57'(m1sq);
    mul_a  = mstep[1] ? var_mag[55:28] : var_mag[27:0];
    mul_b  = mstep[0] ? pref[55:28] : pref[27:0];
    mul_p  = 56'(mul_a) * 56'(mul_b);
    mul_sh = 7'(28 * (32'(mstep[0]) + 32'(mstep[1])));
    // The result is the product shifted down by 38, clipped to 32 signed bits.
    if (var_neg) begin
      sus_k = (acc[111:69] != '0) ? 32'h8000_0000 : 32'(-acc[69:38]);
    end else begin
      sus_k = (acc[111:69] != '0) ? 32'h7FFF_FFFF : {1'b0, acc[68:38]};
    end
  end

  fsa_divider u_div1 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd1),
    .divisor  (count),
    .done     (div1_done),
    .quotient (q1)
  );

  fsa_divider u_div2 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd2),
    .divisor  (count),
    .done     (div2_done),
    .quotient (q2)
  );

  assign div_start = state == ST_RD_DIV;

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      s1_row <= s1_mem[item.element];
      s2_row <= s2_mem[item.element];
      sat_rd <= sat_mem[item.element];
      row_ok <= row_set[item.element];
    end
    if (state == ST_ACC_WR) begin
      s1_mem[el] <= s1_new;
      s2_mem[el] <= s2_new;
    end
    if (accept && item.command == fsa_pkg::CMD_LOAD && present) begin
      sat_mem[item.element] <= item.saturation_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      row_set      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != ST_RD_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            el       <= item.element;
            itemp    <= item.inv_temperature;
            zero_res <= !present || count == '0;
            no_samp  <= count == '0;
            for (int i = 0; i < NC; i++) begin
              vv[i]  <= v_next[i];
              sus[i] <= '0;
            end
            unique case (item.command)
              fsa_pkg::CMD_ACC: begin
                if (item.sample_end && count != {CB{1'b1}}) begin
                  count <= count + CB'(1);
                end
                state <= present ? ST_ACC_SQ : ST_IDLE;
              end
              fsa_pkg::CMD_READ: state <= ST_RD_PREF;
              fsa_pkg::CMD_CLEAR: begin
                count   <= '0;
                row_set <= '0;
              end
              fsa_pkg::CMD_LOAD: ;
              default: ;
            endcase
          end
        end
        ST_ACC_SQ: begin
          for (int i = 0; i < NC; i++) begin
            sq[i] <= 31'(32'(vv[i] * vv[i]));
          end
          state <= ST_ACC_WR;
        end
        ST_ACC_WR: begin
          row_set[el] <= 1'b1;
          state       <= ST_IDLE;
        end
        ST_RD_PREF: begin
          pref  <= 56'(itemp) * 56'(sat_rd);
          k     <= '0;
          state <= zero_res ? ST_RD_OUT : ST_RD_DIV;
        end
        ST_RD_DIV: begin
          state <= ST_RD_WAIT;
        end
        ST_RD_WAIT: begin
          if (div1_done && div2_done) begin
            state <= ST_RD_SQ;
          end
        end
        ST_RD_SQ: begin
          m1sq  <= m1prod[63:30];
          state <= ST_RD_VAR;
        end
        ST_RD_VAR: begin
          var_neg <= diff[56];
          var_mag <= diff[56] ? 56'(-diff) : diff[55:0];
          acc     <= '0;
          mstep   <= '0;
          state   <= ST_RD_MUL;
        end
        ST_RD_MUL: begin
          acc   <= acc + (112'(mul_p) << mul_sh);
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) begin
            state <= ST_RD_RES;
          end
        end
        ST_RD_RES: begin
          sus[k] <= sus_k;
          k      <= k + 2'd1;
          state  <= (k == 2'(NC - 1)) ? ST_RD_OUT : ST_RD_DIV;
        end
        ST_RD_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid       <= 1'b1;
            result.element_out <= el;
            result.sus_x       <= sus[0];
            result.sus_y       <= sus[1];
            result.sus_z       <= sus[2];
            result.sus_len     <= sus[3];
            result.no_samples  <= no_samp;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/fsa_checker.sv -----
// Port-level checks of the accumulator and their binding to the top level.
`default_nettype none
module fsa_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               item_valid,
  input wire logic               item_ready,
  input wire fsa_pkg::in_item_t  item,
  input wire logic               result_valid,
  input wire logic               result_ready,
  input wire fsa_pkg::out_item_t result
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // With no samples every susceptibility reads zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.no_samples |->
      result.sus_x == 0 && result.sus_y == 0 && result.sus_z == 0 && result.sus_len == 0)
    else $error("nonzero result without samples");

  // Accumulate and read transfers keep the block busy for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready &&
      (item.command == fsa_pkg::CMD_ACC || item.command == fsa_pkg::CMD_READ)
      |=> !item_ready)
    else $error("item taken during read-modify-write");

  // A result appears only after a read transfer has made the block busy.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !item_ready || !$past(item_ready))
    else $error("result without a read in progress");

endmodule

bind fluctuation_susceptibility_accumulator fsa_checker u_fsa_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire

// ----- tb/sv/fluctuation_susceptibility_accumulator_tb.sv -----
// Testbench of the fluctuation susceptibility accumulator: predicts each readout and checks it.
`timescale 1ns / 1ps
`default_nettype none
module fluctuation_susceptibility_accumulator_tb;
  import fsa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_item_t result;

  always #1 clk = ~clk;

  fluctuation_susceptibility_accumulator i_dut (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item_ready(item_ready),
    .item(item), .result_valid(result_valid), .result_ready(result_ready),
    .result(result)
  );

  localparam longint SUM1_HI = 64'sd549755813887;
  localparam longint SUM1_LO = -64'sd549755813888;
  localparam logic [63:0] SUM2_HI = 64'd72057594037927935;

  // Predicted state of the block.
  longint sum1 [MAX_ELEMENTS*4];
  logic [63:0] sum2 [MAX_ELEMENTS*4];
  logic [31:0] sat_moment [MAX_ELEMENTS];
  logic [63:0] samples;

  out_item_t readouts [$];
  int errors = 0;
  int rx_stall_cycles = 0;
  bit in_burst = 1'b1;
  int burst_left = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint scale_comp(input longint m, input longint mm);
    longint p;
    p = m * mm;
    if (p < 0) p -= 65535;
    return p / 65536;
  endfunction

  function automatic logic [31:0] susceptibility(input longint s1, input logic [63:0] s2,
                                                 input logic [63:0] n, input logic [63:0] pref);
    longint m1, m1sq, var_q;
    logic [63:0] mag, r, am;
    logic [127:0] prod;
    bit neg;
    m1 = (s1 * 32768) / longint'(n);
    if (m1 > 64'sd2147483648) m1 = 64'sd2147483648;
    if (m1 < -64'sd2147483648) m1 = -64'sd2147483648;
    am = (m1 < 0) ? -m1 : m1;
    m1sq = longint'((am * am) >> 30);
    var_q = longint'(s2 / n) - m1sq;
    neg = var_q < 0;
    mag = neg ? -var_q : var_q;
    prod = pref * mag;
    if ((prod >> 38) > 128'hFFFF_FFFF_FFFF_FFFF) r = '1;
    else r = prod[101:38];
    if (neg) begin
      if (r > 64'd2147483648) r = 64'd2147483648;
      return 32'(64'd0 - r);
    end
    if (r > 64'd2147483647) r = 64'd2147483647;
    return r[31:0];
  endfunction

  // Updates the predicted state for one accepted item.
  task automatic predict_item(input in_item_t it);
    longint v [4];
    longint s;
    logic [63:0] sq, pref;
    logic [31:0] sus [4];
    int idx;
    out_item_t o;
    case (it.command)
      CMD_ACC: begin
        v[0] = scale_comp(longint'(it.mag_x), longint'(it.mag_len));
        v[1] = scale_comp(longint'(it.mag_y), longint'(it.mag_len));
        v[2] = scale_comp(longint'(it.mag_z), longint'(it.mag_len));
        v[3] = longint'(it.mag_len) / 2;
        for (int k = 0; k < 4; k++) begin
          idx = it.element * 4 + k;
          s = sum1[idx] + v[k];
          if (s > SUM1_HI) s = SUM1_HI;
          if (s < SUM1_LO) s = SUM1_LO;
          sum1[idx] = s;
          sq = v[k] * v[k];
          sum2[idx] = (sum2[idx] > SUM2_HI - sq) ? SUM2_HI : sum2[idx] + sq;
        end
        if (it.sample_end && samples < (64'd1 << COUNT_BITS) - 1) samples++;
      end
      CMD_CLEAR: begin
        foreach (sum1[i]) begin
          sum1[i] = 0;
          sum2[i] = 0;
        end
        samples = 0;
      end
      CMD_LOAD: begin
        sat_moment[it.element] = it.saturation_value;
      end
      default: begin
        pref = 64'(it.inv_temperature) * 64'(sat_moment[it.element]);
        for (int k = 0; k < 4; k++)
          sus[k] = (samples == 0) ? 32'd0
                   : susceptibility(sum1[it.element*4+k], sum2[it.element*4+k], samples, pref);
        o.element_out = it.element;
        o.sus_x = sus[0];
        o.sus_y = sus[1];
        o.sus_z = sus[2];
        o.sus_len = sus[3];
        o.no_samples = (samples == 0);
        readouts.push_back(o);
      end
    endcase
  endtask

  // Sends one item, honoring the burst pattern of the sender. Valid stays high
  // into the next item unless a gap follows.
  task automatic send_item(input in_item_t it, input bit no_gaps = 1'b0);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 2) == 0) begin
          item_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      burst_left--;
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_item(it);
  endtask

  function automatic in_item_t random_fields();
    in_item_t it;
    it.command = CMD_ACC;
    it.element = EL_W'($urandom_range(0, MAX_ELEMENTS - 1));
    it.mag_x = 16'($urandom);
    it.mag_y = 16'($urandom);
    it.mag_z = 16'($urandom);
    it.mag_len = 16'($urandom);
    it.sample_end = 1'($urandom_range(0, 1));
    it.inv_temperature = 24'($urandom);
    it.saturation_value = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_item(input cmd_t c, input int el);
    in_item_t it;
    it = random_fields();
    it.command = c;
    it.element = EL_W'(el);
    return it;
  endfunction

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (readouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Load every saturation entry so that any later read is in contract.
  task automatic test_load_all();
    in_item_t it;
    for (int e = 0; e < MAX_ELEMENTS; e++) begin
      it = make_item(CMD_LOAD, e);
      if (e == 0) it.saturation_value = '1;
      if (e == 1) it.saturation_value = '0;
      if (e == 2) it.saturation_value = 32'h100;
      send_item(it);
    end
  endtask

  task automatic test_directed();
    in_item_t it;
    send_item(make_item(CMD_READ, 3));
    it = make_item(CMD_ACC, 0);
    it.mag_x = 16'sh7FFF; it.mag_y = 16'sh8000; it.mag_z = '0; it.mag_len = '1;
    it.sample_end = 1'b1;
    send_item(it);
    it.mag_x = 16'sh8000; it.mag_y = 16'sh7FFF; it.mag_z = '1; it.mag_len = '0;
    send_item(it);
    it.mag_x = '1; it.mag_len = 16'd1; it.sample_end = 1'b0;
    send_item(it);
    for (int e = 0; e < 3; e++) begin
      it = make_item(CMD_READ, e);
      it.inv_temperature = (e == 0) ? 24'hFFFFFF : (e == 1) ? 24'd0 : 24'h010000;
      send_item(it);
    end
    send_item(make_item(CMD_READ, MAX_ELEMENTS - 1));
    send_item(make_item(CMD_CLEAR, 0));
    send_item(make_item(CMD_READ, 0));
    wait_drained();
  endtask

  // Sends one element many full-scale samples with no gaps, then reads it.
  task automatic test_sum_limits();
    in_item_t it;
    for (int i = 0; i < 20; i++) begin
      it = make_item(CMD_ACC, 5);
      it.mag_x = 16'sh8000; it.mag_y = 16'sh7FFF; it.mag_len = '1; it.sample_end = 1'b1;
      send_item(it, 1'b1);
    end
    send_item(make_item(CMD_READ, 5));
    wait_drained();
  endtask

  // The receiver stalls for a long time while accumulates and reads keep coming.
  task automatic test_back_pressure();
    rx_stall_cycles = 3000;
    for (int i = 0; i < 40; i++)
      send_item(make_item((i % 4 == 3) ? CMD_READ : CMD_ACC, $urandom_range(0, 7)), 1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    in_item_t it;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) it = make_item(CMD_ACC, $urandom_range(0, 7));
      else if (pick < 94) it = make_item(CMD_READ, $urandom_range(0, 7));
      else if (pick < 97) it = make_item(CMD_LOAD, $urandom_range(0, MAX_ELEMENTS - 1));
      else it = make_item(CMD_CLEAR, 0);
      if ($urandom_range(0, 9) == 0) it.mag_len = 16'hFFFF;
      send_item(it);
    end
    wait_drained();
  endtask

  // Receiver: long hold-offs on request, otherwise a stall pattern of its own.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (rx_stall_cycles > 0) begin
      rx_stall_cycles <= rx_stall_cycles - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 3) != 0) || in_burst;
      if ($urandom_range(0, 63) == 0) in_burst <= ~in_burst;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (readouts.size() == 0) begin
        report("unexpected transfer", 64'(result.element_out), 64'd0);
      end else begin
        want = readouts.pop_front();
        if (result.element_out !== want.element_out)
          report("element_out", 64'(result.element_out), 64'(want.element_out));
        if (result.sus_x !== want.sus_x)
          report("sus_x", 64'(result.sus_x), 64'(want.sus_x));
        if (result.sus_y !== want.sus_y)
          report("sus_y", 64'(result.sus_y), 64'(want.sus_y));
        if (result.sus_z !== want.sus_z)
          report("sus_z", 64'(result.sus_z), 64'(want.sus_z));
        if (result.sus_len !== want.sus_len)
          report("sus_len", 64'(result.sus_len), 64'(want.sus_len));
        if (result.no_samples !== want.no_samples)
          report("no_samples", 64'(result.no_samples), 64'(want.no_samples));
      end
    end
  end

  initial begin
    foreach (sum1[i]) begin
      sum1[i] = 0;
      sum2[i] = 0;
    end
    foreach (sat_moment[i]) sat_moment[i] = 0;
    samples = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_all();
    test_directed();
    test_sum_limits();
    test_back_pressure();
    test_random(950);
    if (readouts.size() != 0) report("results left over", 64'(readouts.size()), 64'd0);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
